@@ hdl/cst_pkg.sv @@
package cst_pkg;

  localparam logic [1:0] OP_LOAD_X = 2'd0;
  localparam logic [1:0] OP_LOAD_Y = 2'd1;
  localparam logic [1:0] OP_SAMPLE = 2'd2;

  localparam logic CFG_SEG_COUNT = 1'b0;
  localparam logic CFG_PERIOD    = 1'b1;

  localparam int ACC_W = 42;
  localparam int DUR_W = 22;

  localparam logic signed [ACC_W-1:0] WIDE_MAX = 42'sd1099511627775;
  localparam logic signed [ACC_W-1:0] WIDE_MIN = -42'sd1099511627775;

  typedef struct packed {
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
    logic signed [31:0] d;
  } coef_t;

  // One Horner step: floor(acc*tau/65536) + add, saturated to +-(2^40-1).
  function automatic logic signed [ACC_W-1:0] horner_step(
    input logic signed [ACC_W-1:0] acc,
    input logic [DUR_W-1:0] tau,
    input logic signed [ACC_W-1:0] add
  );
    logic signed [ACC_W+DUR_W:0] p;
    logic signed [ACC_W+DUR_W:0] s;
    begin
      p = acc * $signed({1'b0, tau});
      s = (p >>> 16) + add;
      if (s > WIDE_MAX) horner_step = WIDE_MAX;
      else if (s < WIDE_MIN) horner_step = WIDE_MIN;
      else horner_step = s[ACC_W-1:0];
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    begin
      if (v > 42'sd2147483647) sat32 = 32'sh7fffffff;
      else if (v < -42'sd2147483648) sat32 = 32'sh80000000;
      else sat32 = v[31:0];
    end
  endfunction

endpackage

@@ hdl/cubic_spline_trajectory_sampler.sv @@
// A sample transaction's result passes the time product, 16 search stages, the table
// read, three Horner stages and the output register. One sample transaction is
// accepted per cycle while the output is not stalled. A load transaction waits while
// any sample is still in the search, so no sample sees a later load.
// Reset: rst_n (synchronous, active low) clears valid bits and sets segment_count
// to 1 and sample_period to 6554; the segment tables are undefined until loaded.
module cubic_spline_trajectory_sampler #(
  parameter int MAX_SEGMENTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_operation,
  input  logic [3:0]         in_segment_slot,
  input  logic [21:0]        in_seg_duration,
  input  logic signed [31:0] in_coef_cubic,
  input  logic signed [31:0] in_coef_square,
  input  logic signed [31:0] in_coef_linear,
  input  logic signed [31:0] in_coef_const,
  input  logic [15:0]        in_sample_num,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_vel_x,
  output logic signed [31:0] out_vel_y,
  output logic [3:0]         out_segment_used,
  output logic               out_past_end,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);
  localparam int SW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int NS = MAX_SEGMENTS;
  localparam int SUMW = 32 + SW + 1;

  // The whole pipeline advances together; it freezes while the output is stalled
  // and holds a result. in_stall follows the same condition, and also holds a
  // load back while a sample still reads the tables.
  logic adv;
  logic [4:0]  seg_count_r;
  logic [15:0] period_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_count_r <= 5'd1;
      period_r    <= 16'd6554;
    end else if (cfg_valid) begin
      if (cfg_index == cst_pkg::CFG_SEG_COUNT) seg_count_r <= cfg_data[4:0];
      else period_r <= cfg_data[15:0];
    end
  end

  // Effective segment count clamped to 1..MAX_SEGMENTS.
  logic [CW-1:0] count_eff;
  always_comb begin
    if (seg_count_r == 5'd0) count_eff = CW'(1);
    else if (32'(seg_count_r) > NS) count_eff = CW'(NS);
    else count_eff = CW'(seg_count_r);
  end

  // Tables: durations in flops (read at each search stage), coefficients in
  // per-slot registers read once after the search.
  logic [21:0]    dur_r  [NS];
  cst_pkg::coef_t cx_r   [NS];
  cst_pkg::coef_t cy_r   [NS];

  logic in_acc;
  logic smp_busy;
  assign in_acc = in_valid && !in_stall;
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv || (smp_busy && (in_operation == cst_pkg::OP_LOAD_X ||
                                          in_operation == cst_pkg::OP_LOAD_Y));

  cst_pkg::coef_t in_coef;
  assign in_coef = '{a: in_coef_cubic, b: in_coef_square, c: in_coef_linear, d: in_coef_const};

  always_ff @(posedge clk) begin
    if (in_acc && 32'(in_segment_slot) < NS) begin
      if (in_operation == cst_pkg::OP_LOAD_X) begin
        dur_r[SW'(in_segment_slot)] <= in_seg_duration;
        cx_r[SW'(in_segment_slot)]  <= in_coef;
      end else if (in_operation == cst_pkg::OP_LOAD_Y) begin
        cy_r[SW'(in_segment_slot)]  <= in_coef;
      end
    end
  end

  // Search pipeline: stage k checks segment k against the running sum.
  logic              sv_r    [NS+1];
  logic [31:0]       st_r    [NS+1];
  logic [SUMW-1:0]   ssum_r  [NS+1];
  logic              sfound_r[NS+1];
  logic [SW-1:0]     sk_r    [NS+1];
  logic [21:0]       stau_r  [NS+1];
  logic [CW-1:0]     scnt_r  [NS+1];

  // A sample reads the tables until it leaves the last search stage.
  always_comb begin
    smp_busy = 1'b0;
    for (int i = 0; i <= NS; i++) smp_busy = smp_busy | sv_r[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r[0] <= 1'b0;
    end else if (adv) begin
      sv_r[0] <= in_acc && in_operation == cst_pkg::OP_SAMPLE;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0]     <= in_sample_num * period_r;
      ssum_r[0]   <= '0;
      sfound_r[0] <= 1'b0;
      sk_r[0]     <= '0;
      stau_r[0]   <= '0;
      scnt_r[0]   <= count_eff;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_search
    logic [SUMW-1:0] sum_nxt;
    logic hit;
    assign sum_nxt = ssum_r[k] + SUMW'(dur_r[k]);
    assign hit = !sfound_r[k] && CW'(k) < scnt_r[k] && sum_nxt >= SUMW'(st_r[k]);
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[k+1] <= 1'b0;
      end else if (adv) begin
        sv_r[k+1] <= sv_r[k];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[k+1]     <= st_r[k];
        ssum_r[k+1]   <= sum_nxt;
        scnt_r[k+1]   <= scnt_r[k];
        sfound_r[k+1] <= sfound_r[k] || hit;
        sk_r[k+1]     <= hit ? SW'(k) : sk_r[k];
        // tau = t - sum before k, which does not exceed the segment's duration.
        stau_r[k+1]   <= hit ? 22'(SUMW'(st_r[k]) - ssum_r[k]) : stau_r[k];
      end
    end
  end

  // Resolve past-end and read the coefficients of the chosen segment.
  logic [SW-1:0] last_k;
  logic [SW-1:0] fk;
  assign last_k = SW'(scnt_r[NS] - CW'(1));
  assign fk = sfound_r[NS] ? sk_r[NS] : last_k;

  logic           rv_r;
  cst_pkg::coef_t rcx_r, rcy_r;
  logic [21:0]    rtau_r;
  logic [SW-1:0]  rk_r;
  logic           rpast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) rv_r <= 1'b0;
    else if (adv) rv_r <= sv_r[NS];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      rcx_r   <= cx_r[fk];
      rcy_r   <= cy_r[fk];
      rtau_r  <= sfound_r[NS] ? stau_r[NS] : dur_r[last_k];
      rk_r    <= fk;
      rpast_r <= !sfound_r[NS];
    end
  end

  // Three Horner stages, with tag bits carried alongside.
  logic          hv_r [3];
  logic [SW-1:0] hk_r [3];
  logic          hp_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r[0] <= 1'b0; hv_r[1] <= 1'b0; hv_r[2] <= 1'b0;
    end else if (adv) begin
      hv_r[0] <= rv_r; hv_r[1] <= hv_r[0]; hv_r[2] <= hv_r[1];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      hk_r[0] <= rk_r;    hk_r[1] <= hk_r[0]; hk_r[2] <= hk_r[1];
      hp_r[0] <= rpast_r; hp_r[1] <= hp_r[0]; hp_r[2] <= hp_r[1];
    end
  end

  logic signed [31:0] px, py, vx, vy;
  cst_horner u_hx (.clk(clk), .adv(adv), .coef(rcx_r), .tau(rtau_r), .pos(px), .vel(vx));
  cst_horner u_hy (.clk(clk), .adv(adv), .coef(rcy_r), .tau(rtau_r), .pos(py), .vel(vy));

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (adv) out_valid <= hv_r[2];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_pos_x        <= px;
      out_pos_y        <= py;
      out_vel_x        <= vx;
      out_vel_y        <= vy;
      out_segment_used <= 4'(hk_r[2]);
      out_past_end     <= hp_r[2];
    end
  end
endmodule

@@ hdl/cst_horner.sv @@
// One axis of Horner evaluation: position and velocity, one step per stage.
module cst_horner (
  input  logic                clk,
  input  logic                adv,
  input  cst_pkg::coef_t      coef,
  input  logic [21:0]         tau,
  output logic signed [31:0]  pos,
  output logic signed [31:0]  vel
);
  logic signed [41:0] p1_r, v1_r, p2_r, v2_r, p3_r;
  logic signed [31:0] c1_r, d1_r, d2_r;
  logic [21:0] t1_r, t2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r <= cst_pkg::horner_step(42'(coef.a), tau, 42'(coef.b));
      v1_r <= cst_pkg::horner_step(42'(coef.a) * 42'sd3, tau, 42'(coef.b) <<< 1);
      c1_r <= coef.c;
      d1_r <= coef.d;
      t1_r <= tau;
      p2_r <= cst_pkg::horner_step(p1_r, t1_r, 42'(c1_r));
      v2_r <= cst_pkg::horner_step(v1_r, t1_r, 42'(c1_r));
      d2_r <= d1_r;
      t2_r <= t1_r;
      p3_r <= cst_pkg::horner_step(p2_r, t2_r, 42'(d2_r));
    end
  end

  // Velocity is ready a stage early; its 42-bit value is delayed to align.
  logic signed [41:0] v3_r;
  always_ff @(posedge clk) begin
    if (adv) v3_r <= v2_r;
  end

  assign pos = cst_pkg::sat32(p3_r);
  assign vel = cst_pkg::sat32(v3_r);
endmodule
